/* rtl/core/ler_pkg.sv */
// Shared types, constants and counter-update functions of the lifetime extreme recorder.
package ler_pkg;

    // Field and counter widths
    localparam int SAMPLE_W  = 16;
    localparam int RUN_W     = 4;
    localparam int DAY_SEC_W = 17;
    localparam int ACC_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_RUN   = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_SECONDS   = 2'd3;

    // Configuration reset values
    localparam logic [RUN_W-1:0]            PERSIST_RST   = 4'd2;
    localparam logic signed [SAMPLE_W-1:0]  TEMP_HIGH_RST = 16'sd1200;
    localparam logic signed [SAMPLE_W-1:0]  TEMP_LOW_RST  = -16'sd50;
    localparam logic [DAY_SEC_W-1:0]        DAY_SEC_RST   = 17'd86400;

    // Record reset values
    localparam logic [SAMPLE_W-1:0]         MIN_VOLT_RST  = 16'hFFFF;
    localparam logic signed [SAMPLE_W-1:0]  MIN_TEMP_RST  = 16'sd32767;

    // Run counter slots
    localparam logic [2:0] CH_MAXV = 3'd0;
    localparam logic [2:0] CH_MINV = 3'd1;
    localparam logic [2:0] CH_CHG  = 3'd2;
    localparam logic [2:0] CH_DIS  = 3'd3;
    localparam logic [2:0] CH_ACHG = 3'd4;
    localparam logic [2:0] CH_ADIS = 3'd5;
    localparam logic [2:0] CH_TEMP = 3'd6;

    // Result of advancing one run counter
    typedef struct packed {
        logic             take;
        logic [RUN_W-1:0] cnt;
    } t_bump;

    // Result of one high/low channel update
    typedef struct packed {
        logic             take_hi;
        logic             take_lo;
        logic [RUN_W-1:0] cnt_hi;
        logic [RUN_W-1:0] cnt_lo;
    } t_track;

    // Count one more sample past the record; take it once the run exceeds the limit
    function automatic t_bump bump(input logic [RUN_W-1:0] cnt, input logic [RUN_W-1:0] limit);
        logic [RUN_W:0] nxt;
        t_bump          res;
        nxt = {1'b0, cnt} + {{RUN_W{1'b0}}, 1'b1};
        if (nxt > {1'b0, limit}) begin
            res.take = 1'b1;
            res.cnt  = '0;
        end else begin
            res.take = 1'b0;
            res.cnt  = nxt[RUN_W-1:0];
        end
        return res;
    endfunction

    // High/low channel: above counts high and clears low, below the opposite, inside clears both
    function automatic t_track track(input logic above, input logic below,
                                     input logic [RUN_W-1:0] cnt_hi,
                                     input logic [RUN_W-1:0] cnt_lo,
                                     input logic [RUN_W-1:0] limit);
        t_bump  b;
        t_track res;
        res = '0;
        if (above) begin
            b = bump(cnt_hi, limit);
            res.take_hi = b.take;
            res.cnt_hi  = b.cnt;
        end else if (below) begin
            b = bump(cnt_lo, limit);
            res.take_lo = b.take;
            res.cnt_lo  = b.cnt;
        end
        return res;
    endfunction

endpackage

/* rtl/core/lifetime_extreme_recorder.sv */
// Lifetime extreme recorder: input register, record update logic and result register.
// A request is taken into the input register; its record update then goes into the
// result register along with the record state.
// Takes one request per cycle while o_stall is low; the result stalls on i_stall alone.
// Reset (synchronous, active low): records go to their reset values, run counters,
// second sum and day count clear, configuration registers take their defaults.
module lifetime_extreme_recorder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // measurement channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [15:0]         i_voltage_sample,
    input  logic signed [15:0]  i_current_sample,
    input  logic signed [15:0]  i_avg_current_sample,
    input  logic signed [15:0]  i_temp_sample,
    input  logic [15:0]         i_elapsed_sec,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [15:0]         o_rec_max_voltage,
    output logic [15:0]         o_rec_min_voltage,
    output logic signed [15:0]  o_rec_max_charge,
    output logic signed [15:0]  o_rec_max_discharge,
    output logic signed [15:0]  o_rec_max_avg_charge,
    output logic signed [15:0]  o_rec_max_avg_discharge,
    output logic signed [15:0]  o_rec_max_temp,
    output logic signed [15:0]  o_rec_min_temp,
    output logic [15:0]         o_day_count,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [16:0]         i_cfg_data
);

    localparam int SW = ler_pkg::SAMPLE_W;
    localparam int RW = ler_pkg::RUN_W;

    // configuration registers
    logic [RW-1:0]                    r_persist_limit;
    logic signed [SW-1:0]             r_temp_high;
    logic signed [SW-1:0]             r_temp_low;
    logic [ler_pkg::DAY_SEC_W-1:0]    r_day_seconds;

    // input stage
    logic                 r_s1_valid;
    logic [SW-1:0]        r_volt;
    logic signed [SW-1:0] r_cur;
    logic signed [SW-1:0] r_avg;
    logic signed [SW-1:0] r_temp;
    logic [SW-1:0]        r_elapsed;

    // records and counters
    logic [SW-1:0]        r_max_volt, n_max_volt;
    logic [SW-1:0]        r_min_volt, n_min_volt;
    logic signed [SW-1:0] r_chg, n_chg;
    logic signed [SW-1:0] r_dis, n_dis;
    logic signed [SW-1:0] r_achg, n_achg;
    logic signed [SW-1:0] r_adis, n_adis;
    logic signed [SW-1:0] r_max_temp, n_max_temp;
    logic signed [SW-1:0] r_min_temp, n_min_temp;
    logic [RW-1:0]        r_run_cnt [ler_pkg::NUM_RUN];
    logic [RW-1:0]        n_run_cnt [ler_pkg::NUM_RUN];
    logic [ler_pkg::ACC_W-1:0] r_sec_acc, n_sec_acc;
    logic [SW-1:0]        r_days, n_days;

    // result stage
    logic r_out_valid;

    // pipeline control
    logic s1_load;
    logic s2_load;

    ler_pkg::t_track trk_v;
    ler_pkg::t_track trk_c;
    ler_pkg::t_track trk_a;
    ler_pkg::t_bump  bmp_t;
    logic            temp_ok;
    logic [ler_pkg::ACC_W-1:0] acc_sum;

    // result register moves when empty or being taken; input register follows it
    assign s2_load     = r_s1_valid && (!r_out_valid || !i_stall);
    assign s1_load     = !r_s1_valid || s2_load;
    assign o_stall     = !s1_load;
    assign o_valid     = r_out_valid;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persist_limit <= ler_pkg::PERSIST_RST;
            r_temp_high     <= ler_pkg::TEMP_HIGH_RST;
            r_temp_low      <= ler_pkg::TEMP_LOW_RST;
            r_day_seconds   <= ler_pkg::DAY_SEC_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ler_pkg::CFG_PERSIST_LIMIT: r_persist_limit <= i_cfg_data[RW-1:0];
                ler_pkg::CFG_TEMP_HIGH:     r_temp_high     <= $signed(i_cfg_data[SW-1:0]);
                ler_pkg::CFG_TEMP_LOW:      r_temp_low      <= $signed(i_cfg_data[SW-1:0]);
                ler_pkg::CFG_DAY_SECONDS:   r_day_seconds   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_valid) begin
            r_volt    <= i_voltage_sample;
            r_cur     <= i_current_sample;
            r_avg     <= i_avg_current_sample;
            r_temp    <= i_temp_sample;
            r_elapsed <= i_elapsed_sec;
        end
    end

    // record update for the registered sample
    always_comb begin
        trk_v = ler_pkg::track(r_volt > r_max_volt, r_volt < r_min_volt,
                               r_run_cnt[ler_pkg::CH_MAXV], r_run_cnt[ler_pkg::CH_MINV],
                               r_persist_limit);
        trk_c = ler_pkg::track(r_cur > r_chg, r_cur < r_dis,
                               r_run_cnt[ler_pkg::CH_CHG], r_run_cnt[ler_pkg::CH_DIS],
                               r_persist_limit);
        trk_a = ler_pkg::track(r_avg > r_achg, r_avg < r_adis,
                               r_run_cnt[ler_pkg::CH_ACHG], r_run_cnt[ler_pkg::CH_ADIS],
                               r_persist_limit);
        bmp_t = ler_pkg::bump(r_run_cnt[ler_pkg::CH_TEMP], r_persist_limit);

        n_run_cnt = r_run_cnt;
        n_run_cnt[ler_pkg::CH_MAXV] = trk_v.cnt_hi;
        n_run_cnt[ler_pkg::CH_MINV] = trk_v.cnt_lo;
        n_run_cnt[ler_pkg::CH_CHG]  = trk_c.cnt_hi;
        n_run_cnt[ler_pkg::CH_DIS]  = trk_c.cnt_lo;
        n_run_cnt[ler_pkg::CH_ACHG] = trk_a.cnt_hi;
        n_run_cnt[ler_pkg::CH_ADIS] = trk_a.cnt_lo;

        n_max_volt = trk_v.take_hi ? r_volt : r_max_volt;
        n_min_volt = trk_v.take_lo ? r_volt : r_min_volt;
        n_chg      = trk_c.take_hi ? r_cur : r_chg;
        n_dis      = trk_c.take_lo ? r_cur : r_dis;
        n_achg     = trk_a.take_hi ? r_avg : r_achg;
        n_adis     = trk_a.take_lo ? r_avg : r_adis;

        // temperature: one shared counter, ignored outside the window
        temp_ok    = (r_temp < r_temp_high) && (r_temp > r_temp_low);
        n_max_temp = r_max_temp;
        n_min_temp = r_min_temp;
        if (temp_ok) begin
            priority if (r_temp > r_max_temp) begin
                n_run_cnt[ler_pkg::CH_TEMP] = bmp_t.cnt;
                if (bmp_t.take) n_max_temp = r_temp;
            end else if (r_temp < r_min_temp) begin
                n_run_cnt[ler_pkg::CH_TEMP] = bmp_t.cnt;
                if (bmp_t.take) n_min_temp = r_temp;
            end else begin
                n_run_cnt[ler_pkg::CH_TEMP] = '0;
            end
        end

        // day accounting
        acc_sum = r_sec_acc + {{(ler_pkg::ACC_W-SW){1'b0}}, r_elapsed};
        if (acc_sum > {{(ler_pkg::ACC_W-ler_pkg::DAY_SEC_W){1'b0}}, r_day_seconds}) begin
            n_sec_acc = '0;
            n_days    = r_days + 16'd1;
        end else begin
            n_sec_acc = acc_sum;
            n_days    = r_days;
        end
    end

    // record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_volt <= '0;
            r_min_volt <= ler_pkg::MIN_VOLT_RST;
            r_chg      <= '0;
            r_dis      <= '0;
            r_achg     <= '0;
            r_adis     <= '0;
            r_max_temp <= '0;
            r_min_temp <= ler_pkg::MIN_TEMP_RST;
            r_run_cnt  <= '{default: '0};
            r_sec_acc  <= '0;
            r_days     <= '0;
        end else if (s2_load) begin
            r_max_volt <= n_max_volt;
            r_min_volt <= n_min_volt;
            r_chg      <= n_chg;
            r_dis      <= n_dis;
            r_achg     <= n_achg;
            r_adis     <= n_adis;
            r_max_temp <= n_max_temp;
            r_min_temp <= n_min_temp;
            r_run_cnt  <= n_run_cnt;
            r_sec_acc  <= n_sec_acc;
            r_days     <= n_days;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            o_rec_max_voltage       <= n_max_volt;
            o_rec_min_voltage       <= n_min_volt;
            o_rec_max_charge        <= n_chg;
            o_rec_max_discharge     <= n_dis;
            o_rec_max_avg_charge    <= n_achg;
            o_rec_max_avg_discharge <= n_adis;
            o_rec_max_temp          <= n_max_temp;
            o_rec_min_temp          <= n_min_temp;
            o_day_count             <= n_days;
        end
    end

endmodule
